/* hw/rtl/sfcd_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor frame decode package
// Shared constants, types and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

  localparam int unsigned FrameBytes  = 5;
  localparam int unsigned HeldBytes   = 4;
  localparam logic [7:0]  CrcPoly     = 8'h31;
  localparam logic [3:0]  HeaderMark  = 4'd9;
  localparam logic [11:0] TempOffset  = 12'd400;

  typedef logic [2:0] pos_t;

  localparam pos_t PosCrcByte = 3'(HeldBytes);

  // Bytes of one complete frame together with the computed CRC.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] rx_crc;
    logic [7:0] calc_crc;
  } frame_t;

  // One decoded result.
  typedef struct packed {
    logic               frame_valid;
    logic               crc_ok;
    logic               header_ok;
    logic [5:0]         sensor_id;
    logic               new_battery;
    logic               spare_bit;
    logic signed [11:0] temperature_tenths;
    logic               weak_battery;
    logic [6:0]         humidity;
    logic [7:0]         received_crc;
  } result_t;

  // MSB-first CRC-8 update over one byte; eight short dependent steps.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] val_in);
    logic [7:0] crc;
    logic [7:0] val;
    logic       top;
    crc = crc_in;
    val = val_in;
    for (int i = 0; i < 8; i++) begin
      top = crc[7] ^ val[7];
      crc = {crc[6:0], 1'b0};
      if (top) begin
        crc = crc ^ CrcPoly;
      end
      val = {val[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/sfcd_if.sv */
// ----------------------------------------------------------------------------
// Sensor frame decode channel interfaces
// Valid/ready channels for incoming frame bytes and decoded results.
// ----------------------------------------------------------------------------
interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic               crc_ok;
  logic               header_ok;
  logic [5:0]         sensor_id;
  logic               new_battery;
  logic               spare_bit;
  logic signed [11:0] temperature_tenths;
  logic               weak_battery;
  logic [6:0]         humidity;
  logic [7:0]         received_crc;

  modport source (output valid, output frame_valid, output crc_ok, output header_ok,
                  output sensor_id, output new_battery, output spare_bit,
                  output temperature_tenths, output weak_battery, output humidity,
                  output received_crc, input ready);
  modport sink   (input valid, input frame_valid, input crc_ok, input header_ok,
                  input sensor_id, input new_battery, input spare_bit,
                  input temperature_tenths, input weak_battery, input humidity,
                  input received_crc, output ready);
endinterface

/* hw/rtl/sfcd_assembler.sv */
// ----------------------------------------------------------------------------
// Sensor frame assembler
// Tracks the byte position, holds bytes 0 to 3 and runs the CRC over them.
// ----------------------------------------------------------------------------
module sfcd_assembler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_accept,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                frame_done,
  output sfcd_pkg::frame_t    frame
);

  sfcd_pkg::pos_t pos_r;
  sfcd_pkg::pos_t pos_nxt;
  sfcd_pkg::pos_t pos_eff;
  logic [7:0]     crc_r;
  logic [7:0]     crc_nxt;
  logic [7:0]     crc_eff;
  logic [7:0]     held_r [sfcd_pkg::HeldBytes];

  // A start flag makes the current byte the first one of a new frame.
  assign pos_eff    = frame_start ? '0 : pos_r;
  assign crc_eff    = frame_start ? '0 : crc_r;
  assign frame_done = (pos_eff == sfcd_pkg::PosCrcByte);

  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (byte_accept) begin
      if (frame_done) begin
        pos_nxt = '0;
        crc_nxt = '0;
      end else begin
        pos_nxt = pos_eff + 3'd1;
        crc_nxt = sfcd_pkg::crc8_byte(crc_eff, data_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && !frame_done) begin
      held_r[pos_eff[1:0]] <= data_byte;
    end
  end

  assign frame.byte0    = held_r[0];
  assign frame.byte1    = held_r[1];
  assign frame.byte2    = held_r[2];
  assign frame.byte3    = held_r[3];
  assign frame.rx_crc   = data_byte;
  assign frame.calc_crc = crc_r;

endmodule

/* hw/rtl/sfcd_decoder.sv */
// ----------------------------------------------------------------------------
// Sensor frame field decoder
// Checks CRC and header and unpacks the fields, including the BCD temperature.
// ----------------------------------------------------------------------------
module sfcd_decoder (
  input  sfcd_pkg::frame_t  frame,
  output sfcd_pkg::result_t result
);

  logic [10:0] bcd_sum;
  logic        crc_ok;
  logic        header_ok;

  // Digits above nine are not rejected; the weighted sum stays below 2048.
  assign bcd_sum = 11'(frame.byte1[3:0]) * 11'd100
                 + 11'(frame.byte2[7:4]) * 11'd10
                 + 11'(frame.byte2[3:0]);

  assign crc_ok    = (frame.rx_crc == frame.calc_crc);
  assign header_ok = (frame.byte0[7:4] == sfcd_pkg::HeaderMark);

  assign result.frame_valid        = crc_ok && header_ok;
  assign result.crc_ok             = crc_ok;
  assign result.header_ok          = header_ok;
  assign result.sensor_id          = {frame.byte0[3:0], frame.byte1[7:6]};
  assign result.new_battery        = frame.byte1[5];
  assign result.spare_bit          = frame.byte1[4];
  assign result.temperature_tenths = $signed({1'b0, bcd_sum} - sfcd_pkg::TempOffset);
  assign result.weak_battery       = frame.byte3[7];
  assign result.humidity           = frame.byte3[6:0];
  assign result.received_crc       = frame.rx_crc;

endmodule

/* hw/rtl/sensor_frame_crc_decode_top.sv */
// ----------------------------------------------------------------------------
// Sensor frame CRC decode, top level
// Assembles five-byte sensor frames, checks CRC-8 and header, emits fields.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on in_if, one per transfer, with frame_start set on the
//   first byte of a frame. A start flag in mid-frame drops the partial frame
//   and restarts assembly; without it, byte counting simply wraps after five.
//   Bytes 0 to 3 are held and folded into the CRC-8 (polynomial 0x31, initial
//   zero, MSB first) as they arrive. The fifth byte is the received CRC.
//   On the fifth byte one result transfer is produced on out_if, whether the
//   frame checks out or not; frame_valid tells the two apart.
//   Latency: the result is shown in the cycle after the fifth byte transfer.
//   Throughput: one byte per cycle unless a waiting result stalls the input.
//   The CRC byte update is eight unrolled steps into the CRC register, and the
//   field decode is a short adder chain from the held bytes to the result register.
//   Stalls: the result register frees as it is taken, so a byte is accepted
//   whenever the result register is empty or being read in the same cycle.
//   While a stalled receiver leaves a result waiting, every byte is held off,
//   whether it ends a frame or not, until the result is taken.
//   Reset: synchronous, active low; clears byte position, CRC and result
//   valid. Held bytes are not cleared, since each frame writes them first.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decode_top (
  input  logic              clk,
  input  logic              rst_n,
  sfcd_in_if.sink           in_if,
  sfcd_out_if.source        out_if
);

  logic              byte_accept;
  logic              frame_done;
  sfcd_pkg::frame_t  frame;
  sfcd_pkg::result_t result;
  sfcd_pkg::result_t out_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  // The result register can take a new result when empty or being drained.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign byte_accept = in_if.valid && in_if.ready;

  sfcd_assembler u_assembler (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .data_byte   (in_if.data_byte),
    .frame_start (in_if.frame_start),
    .frame_done  (frame_done),
    .frame       (frame)
  );

  sfcd_decoder u_decoder (
    .frame  (frame),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (byte_accept && frame_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload is loaded only when a frame completes.
  always_ff @(posedge clk) begin
    if (byte_accept && frame_done) begin
      out_data_r <= result;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.frame_valid        = out_data_r.frame_valid;
  assign out_if.crc_ok             = out_data_r.crc_ok;
  assign out_if.header_ok          = out_data_r.header_ok;
  assign out_if.sensor_id          = out_data_r.sensor_id;
  assign out_if.new_battery        = out_data_r.new_battery;
  assign out_if.spare_bit          = out_data_r.spare_bit;
  assign out_if.temperature_tenths = out_data_r.temperature_tenths;
  assign out_if.weak_battery       = out_data_r.weak_battery;
  assign out_if.humidity           = out_data_r.humidity;
  assign out_if.received_crc       = out_data_r.received_crc;

`ifndef NO_ASSERTIONS
  // A frame-ending transfer always shows a result in the next cycle.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    byte_accept && frame_done |=> out_valid_r)
    else $error("frame end did not produce a result");

  // A taken result is not shown again unless a new frame ended.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_if.ready && !(byte_accept && frame_done) |=> !out_valid_r)
    else $error("result repeated after transfer");

  // The overall verdict agrees with its two checks.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.frame_valid == (out_data_r.crc_ok && out_data_r.header_ok)))
    else $error("frame_valid disagrees with crc_ok and header_ok");
`endif

endmodule

/* sim/sensor_frame_crc_decode_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame CRC decode testbench
// Streams frame bytes into the decoder and checks every decoded result against
// a cycle-free software decode of the same bytes. The run covers directed
// corner frames, a long random mix of good, corrupted and broken frames, a
// long receiver hold-off, drain pauses and a final stretch without idling.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decode_top_test;

  // A generous ceiling on the whole run, far above the slowest legal run.
  localparam int unsigned TimeoutNs   = 4_000_000;
  // Cycles to wait after the last result; the block registers its result.
  localparam int unsigned SettleCycles = 4;
  // Length of the long receiver hold-off, in clock cycles.
  localparam int unsigned HoldOffCycles = 120;

  logic clk = 1'b0;
  logic rst_n;

  sfcd_in_if  in_ch ();
  sfcd_out_if out_ch ();

  sensor_frame_crc_decode_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decode state mirrored from the block: running CRC, byte position and the
  // four held bytes. Reset happens once, so the declaration values are the
  // post-reset state.
  logic [7:0]  asm_crc = 8'h00;
  int unsigned asm_pos = 0;
  logic [7:0]  asm_held [sfcd_pkg::HeldBytes];

  // Decoded frames that the block still owes us, oldest first.
  sfcd_pkg::result_t decoded_due [$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;

  // Traffic shaping knobs, changed by the tests as they go.
  bit          tx_gaps     = 1'b1;
  bit          rx_stalls   = 1'b1;
  int unsigned rx_hold_len = 0;

  // One MSB-first step of the CRC-8 over a whole byte: fold the data into the
  // accumulator first, then shift out eight bits against the polynomial.
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    r = acc ^ data;
    repeat (8) begin
      r = r[7] ? ({r[6:0], 1'b0} ^ sfcd_pkg::CrcPoly) : {r[6:0], 1'b0};
    end
    return r;
  endfunction

  // Advance the mirrored decoder by one accepted byte. On the fifth byte of a
  // frame the decoded fields are queued as the result the block must produce.
  function automatic void predict_decode(input logic [7:0] rx_byte, input logic start);
    sfcd_pkg::result_t r;
    int                t;
    // A start flag drops whatever was assembled and restarts at byte zero.
    if (start || asm_pos >= sfcd_pkg::FrameBytes) begin
      asm_pos = 0;
      asm_crc = 8'h00;
    end
    if (asm_pos < sfcd_pkg::HeldBytes) begin
      asm_held[asm_pos] = rx_byte;
      asm_crc = crc_fold(asm_crc, rx_byte);
      asm_pos++;
    end else begin
      // Three BCD nibbles, taken as they are even when above nine.
      t = int'(asm_held[1][3:0]) * 100 + int'(asm_held[2][7:4]) * 10
        + int'(asm_held[2][3:0]) - 400;
      r.crc_ok             = (rx_byte == asm_crc);
      r.header_ok          = (asm_held[0][7:4] == sfcd_pkg::HeaderMark);
      r.frame_valid        = r.crc_ok && r.header_ok;
      r.sensor_id          = {asm_held[0][3:0], asm_held[1][7:6]};
      r.new_battery        = asm_held[1][5];
      r.spare_bit          = asm_held[1][4];
      r.temperature_tenths = t[11:0];
      r.weak_battery       = asm_held[3][7];
      r.humidity           = asm_held[3][6:0];
      r.received_crc       = rx_byte;
      decoded_due.push_back(r);
      asm_pos = 0;
      asm_crc = 8'h00;
    end
  endfunction

  // Prints one line for a field that differs and counts it.
  task automatic report_diff(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
    end
  endtask

  // Offers one byte and returns at the rising edge where it is transferred.
  // It is called at a rising edge; ready is looked at on the falling edge,
  // where everything driven at the rising edge has long settled, so the
  // outcome never depends on event order within a time step. The caller must,
  // in the same step, either offer the next byte or lower valid.
  task automatic send_byte(input logic [7:0] rx_byte, input logic start);
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= rx_byte;
    in_ch.frame_start <= start;
    forever begin
      @(negedge clk);
      if (in_ch.ready === 1'b1) break;
    end
    @(posedge clk);
    predict_decode(rx_byte, start);
    bytes_sent++;
  endtask

  // Sometimes drops valid for a random pause while tx_gaps is set.
  task automatic sender_pause();
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Lowers valid and holds off until every owed result has been taken.
  // Waits on the clock before it checks, so valid is not raised again in the
  // step where it was lowered.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (decoded_due.size() != 0);
  endtask

  // Sends the four data bytes and a CRC byte. The CRC byte is the correct one
  // with crc_flip XORed in, so a zero flip gives a frame that checks out.
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [7:0] crc_flip, input logic start);
    logic [7:0] fcs;
    fcs = crc_fold(crc_fold(crc_fold(crc_fold(8'h00, b0), b1), b2), b3) ^ crc_flip;
    send_byte(b0, start);
    sender_pause();
    send_byte(b1, 1'b0);
    sender_pause();
    send_byte(b2, 1'b0);
    sender_pause();
    send_byte(b3, 1'b0);
    sender_pause();
    send_byte(fcs, 1'b0);
    sender_pause();
  endtask

  // One random frame. Most are well formed with random content and a header
  // of nine; some carry a single flipped CRC bit or a random CRC; a few are
  // cut short or are loose bytes with random start flags, so the restart and
  // wrap paths get exercised from every byte position.
  task automatic send_random_frame();
    logic [7:0]  fb [sfcd_pkg::HeldBytes];
    logic [7:0]  flip;
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (kind < 85) fb[0][7:4] = sfcd_pkg::HeaderMark;
    if (kind >= 90) begin
      cut = $urandom_range(1, 4);
      for (int i = 0; i < cut; i++) begin
        if (kind >= 96) begin
          send_byte(8'($urandom), 1'($urandom));
        end else begin
          send_byte(fb[i], i == 0);
        end
        sender_pause();
      end
    end else begin
      if (kind < 70) begin
        flip = 8'h00;
      end else if (kind < 80) begin
        flip = 8'h01 << $urandom_range(0, 7);
      end else begin
        flip = 8'($urandom);
      end
      // The start flag is left off now and then; the byte count then wraps.
      send_frame(fb[0], fb[1], fb[2], fb[3], flip, $urandom_range(0, 7) != 0);
    end
  endtask

  // ---------------------------------------------------------------- tests ---

  // Right after reset the position is zero, so a frame needs no start flag.
  // All fields at their top values: ID 63, every flag set, 1265 tenths.
  task automatic test_first_frame_after_reset();
    send_frame(8'h9F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
  endtask

  // Back to back with no start flag, relying on the wrap after five bytes.
  // All fields at their bottom values, -400 tenths, and a CRC that is wrong
  // in every bit together with a bad header.
  task automatic test_wrap_and_low_extremes();
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
  endtask

  // A start flag in mid-frame drops the partial frame; only the restarted
  // frame may produce a result. Its CRC is off by one bit, header is good.
  task automatic test_restart_mid_frame();
    send_byte(8'h91, 1'b1);
    sender_pause();
    send_byte(8'h22, 1'b0);
    sender_pause();
    send_frame(8'h95, 8'h4A, 8'h23, 8'h81, 8'h01, 1'b1);
  endtask

  // Good CRC with a wrong header, and a temperature hundreds nibble above nine.
  task automatic test_bad_header_good_crc();
    send_frame(8'hA5, 8'h3C, 8'h99, 8'h7E, 8'h00, 1'b1);
  endtask

  // The bulk of the run, in chunks that each draw their own idling mix so
  // that some stretches run with no gaps or stalls at all.
  task automatic test_random_frames(input int unsigned byte_target);
    while (bytes_sent < byte_target) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      repeat (40) send_random_frame();
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // The receiver holds off for a long stretch while bytes keep coming with no
  // gaps; the result register fills and the block must stall its input.
  task automatic test_receiver_holdoff();
    tx_gaps     = 1'b0;
    rx_hold_len = HoldOffCycles;
    repeat (8) begin
      send_frame(8'($urandom_range(144, 159)), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'h00, 1'b1);
    end
    tx_gaps = 1'b1;
  endtask

  // The sender goes quiet until every owed result is in, several times over.
  task automatic test_sender_drain();
    repeat (6) begin
      repeat (3) send_random_frame();
      wait_drain();
    end
  endtask

  // The last part of the run has no idling on either side.
  task automatic test_unthrottled_tail(input int unsigned byte_count);
    int unsigned stop_at;
    stop_at   = bytes_sent + byte_count;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // ------------------------------------------------------------ processes ---

  // Receiver: ready is mostly high, drops for random bursts when stalls are
  // on, and obeys a requested long hold-off, counted here in cycles.
  initial begin : result_receiver
    int unsigned stall_len;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        out_ch.ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_len = $urandom_range(1, 10);
        repeat (stall_len) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checker: a result transfer happens at the rising edge after a falling
  // edge that shows valid and ready high, so each transfer is seen exactly
  // once here and compared against the oldest owed decode.
  initial begin : result_checker
    sfcd_pkg::result_t want;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && $isunknown(out_ch.valid)) begin
        report_diff("result valid unknown", 16'(out_ch.valid), 16'd0);
      end
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (decoded_due.size() == 0) begin
          report_diff("result with none owed", 16'd1, 16'd0);
        end else begin
          want = decoded_due.pop_front();
          report_diff("frame_valid", 16'(out_ch.frame_valid), 16'(want.frame_valid));
          report_diff("crc_ok", 16'(out_ch.crc_ok), 16'(want.crc_ok));
          report_diff("header_ok", 16'(out_ch.header_ok), 16'(want.header_ok));
          report_diff("sensor_id", 16'(out_ch.sensor_id), 16'(want.sensor_id));
          report_diff("new_battery", 16'(out_ch.new_battery), 16'(want.new_battery));
          report_diff("spare_bit", 16'(out_ch.spare_bit), 16'(want.spare_bit));
          report_diff("temperature_tenths", 16'(unsigned'(out_ch.temperature_tenths)),
                      16'(unsigned'(want.temperature_tenths)));
          report_diff("weak_battery", 16'(out_ch.weak_battery), 16'(want.weak_battery));
          report_diff("humidity", 16'(out_ch.humidity), 16'(want.humidity));
          report_diff("received_crc", 16'(out_ch.received_crc), 16'(want.received_crc));
        end
      end
    end
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  initial begin : watchdog
    #(TimeoutNs);
    $display("sensor_frame_crc_decode_top: mismatch");
    $finish;
  end

  // Main sequence: reset once, then the tests in turn, then drain and judge.
  initial begin : main_sequence
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_first_frame_after_reset();
    test_wrap_and_low_extremes();
    test_restart_mid_frame();
    test_bad_header_good_crc();
    test_random_frames(1600);
    test_receiver_holdoff();
    test_sender_drain();
    test_unthrottled_tail(200);

    // All bytes are in; wait for the owed results, then a few quiet cycles.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (decoded_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("sensor_frame_crc_decode_top: match");
    end else begin
      $display("sensor_frame_crc_decode_top: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sfcd_pkg.sv
hw/rtl/sfcd_if.sv
hw/rtl/sfcd_assembler.sv
hw/rtl/sfcd_decoder.sv
hw/rtl/sensor_frame_crc_decode_top.sv
sim/sensor_frame_crc_decode_top_test.sv
